### src/apsp_pkg.sv
// Shared constants and types of the all-pairs hop distance unit.
package apsp_pkg;

  // Graph size and field widths
  localparam int unsigned MAX_NODES = 64;
  localparam int unsigned NODE_W    = $clog2(MAX_NODES);
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned DIST_W    = 7;
  localparam int unsigned PAIR_W    = 13;
  localparam int unsigned CFG_W     = 7;

  // APB register file
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // Register indexes (taken from paddr[2])
  localparam logic CFG_NODE_COUNT = 1'b0;
  localparam logic CFG_DIAM_LIMIT = 1'b1;

  // Levels saturate at the top of the 7-bit range
  localparam logic [DIST_W-1:0] LEVEL_CAP = 7'd127;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RUN  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

  typedef logic [MAX_NODES-1:0] row_t;
  typedef logic [MAX_NODES-1:0][DIST_W-1:0] dist_vec_t;

  // One row of the distance store: reach bits plus the row's distances
  typedef struct packed {
    row_t      reach;
    dist_vec_t levels;
  } dist_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] node_count;
    logic [CFG_W-1:0] diameter_limit;
  } cfg_t;

  // Row memory port control
  typedef struct packed {
    logic              re;
    logic [NODE_W-1:0] raddr;
    logic              we;
    logic [NODE_W-1:0] waddr;
  } mem_ctl_t;

endpackage

### src/apsp_req_if.sv
// Request channel: command, source node and destination node.
interface apsp_req_if;
  logic                        valid;
  logic                        ready;
  logic [apsp_pkg::FUNC_W-1:0] func;
  logic [apsp_pkg::NODE_W-1:0] src;
  logic [apsp_pkg::NODE_W-1:0] dst;

  modport source (output valid, func, src, dst, input ready);
  modport sink   (input valid, func, src, dst, output ready);
endinterface

### src/apsp_rsp_if.sv
// Response channel: distance, pair count and last level.
interface apsp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [apsp_pkg::DIST_W-1:0] distance;
  logic [apsp_pkg::PAIR_W-1:0] pairs_found;
  logic [apsp_pkg::DIST_W-1:0] last_level;

  modport source (output valid, distance, pairs_found, last_level, input ready);
  modport sink   (input valid, distance, pairs_found, last_level, output ready);
endinterface

### src/apsp_ram.sv
// Row memory with one write and one registered read port; unwritten rows read as zero.
module apsp_ram #(
  parameter int unsigned WIDTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  apsp_pkg::mem_ctl_t ctl_i,
  input  logic [WIDTH-1:0]   wdata_i,
  output logic [WIDTH-1:0]   rdata_o
);
  import apsp_pkg::*;

  logic [WIDTH-1:0]     mem_q [MAX_NODES];
  logic [WIDTH-1:0]     rdata_q;
  logic [MAX_NODES-1:0] valid_q;
  logic                 rvld_q;

  // Storage array and read register
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[ctl_i.waddr] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[ctl_i.raddr];
    end
  end

  // Per-row written flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[ctl_i.waddr] <= 1'b1;
      end
      if (ctl_i.re) begin
        rvld_q <= valid_q[ctl_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

### src/apsp_cfg_regs.sv
// APB register file: node count and diameter limit.
module apsp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apsp_pkg::CFG_AW-1:0]   paddr,
  input  logic [apsp_pkg::CFG_DW-1:0]   pwdata,
  output logic [apsp_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output apsp_pkg::cfg_t                cfg_o
);
  import apsp_pkg::*;

  logic             wr_en;
  logic             reg_idx;
  logic [CFG_W-1:0] node_count_q;
  logic [CFG_W-1:0] diam_limit_q;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CFG_W'(MAX_NODES);
      diam_limit_q <= CFG_W'(MAX_NODES);
    end else if (wr_en) begin
      if (reg_idx == CFG_NODE_COUNT) begin
        node_count_q <= pwdata[CFG_W-1:0];
      end else begin
        diam_limit_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    if (reg_idx == CFG_DIAM_LIMIT) begin
      prdata = CFG_DW'(diam_limit_q);
    end else begin
      prdata = CFG_DW'(node_count_q);
    end
  end

  assign cfg_o.node_count     = node_count_q;
  assign cfg_o.diameter_limit = diam_limit_q;

endmodule

### src/unweighted_apsp_matrix_power_unit.sv
// Top level: all-pairs hop distances by boolean matrix powers over two row memories.
//
//  channel   dir  handshake        payload
//  req_i     in   valid/ready      func, src, dst
//  rsp_o     out  valid/ready      distance, pairs_found, last_level
//  apb       in   psel/penable     paddr, pwdata, prdata (node_count @0, diameter_limit @4)
//
//  Edge loads, reads and unused codes overlap: a new one is taken while the last one finishes
//  in the execute stage, when the response register is free; the result is registered in the
//  response register (read, modify, write of row src). In a run the inner cost is one
//  adjacency row read per cycle from the adjacency port.
//  Reset clears both memories at once through per-row written flags: no clearing pass.
//  Requests stall while a run is busy or while a finished response is not taken.
module unweighted_apsp_matrix_power_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  apsp_req_if.sink                    req_i,
  apsp_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [apsp_pkg::CFG_AW-1:0] paddr,
  input  logic [apsp_pkg::CFG_DW-1:0] pwdata,
  output logic [apsp_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import apsp_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    ST_PIPE,
    ST_CP_RD,
    ST_CP_WR,
    ST_ROW_RD,
    ST_ACC,
    ST_WB,
    ST_CNT,
    ST_RND,
    ST_DONE
  } state_e;

  function automatic logic [CNT_W-1:0] popcount(input row_t v);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int k = 0; k < MAX_NODES; k++) begin
      s = s + CNT_W'(v[k]);
    end
    return s;
  endfunction

  state_e            state_q, state_d;
  cfg_t              cfg;
  logic [CFG_W-1:0]  n_act;
  logic [NODE_W-1:0] n_last;
  row_t              col_mask;

  mem_ctl_t          adj_ctl, dist_ctl;
  row_t              adj_wdata, adj_rdata;
  dist_row_t         dist_wdata, dist_rdata;

  // Execute stage of the edge/read path
  logic              b_vld_q, b_vld_d;
  logic [FUNC_W-1:0] b_func_q, b_func_d;
  logic [NODE_W-1:0] b_src_q, b_src_d;
  logic [NODE_W-1:0] b_dst_q, b_dst_d;

  // Forwarding of a write that met a read of the same row
  logic              fwd_vld_q, fwd_vld_d;
  logic [NODE_W-1:0] fwd_row_q, fwd_row_d;
  row_t              fwd_adj_q, fwd_adj_d;
  dist_row_t         fwd_dist_q, fwd_dist_d;

  // Response register
  logic              out_vld_q, out_vld_d;
  logic [DIST_W-1:0] o_dist_q, o_dist_d;
  logic [PAIR_W-1:0] o_pairs_q, o_pairs_d;
  logic [DIST_W-1:0] o_level_q, o_level_d;

  // Run state
  logic [PAIR_W-1:0] pair_q, pair_d;
  logic [PAIR_W-1:0] full_q, full_d;
  logic [PAIR_W-1:0] round_add_q, round_add_d;
  logic [DIST_W-1:0] level_q, level_d;
  logic [DIST_W-1:0] final_q, final_d;
  logic [NODE_W-1:0] row_q, row_d;
  logic [NODE_W-1:0] cnt_q, cnt_d;
  row_t              acc_q, acc_d;
  row_t              new_q, new_d;

  logic              fwd_hit, out_free, b_run, b_go, in_ready, in_acc;
  logic              edge_ok, add_wr, new_pair, stop;
  logic [PAIR_W-1:0] pair_sum;
  row_t              adj_cur, new_bits;
  dist_row_t         dist_cur;

  apsp_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  apsp_ram #(.WIDTH($bits(row_t))) u_adj_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (adj_ctl),
    .wdata_i (adj_wdata),
    .rdata_o (adj_rdata)
  );

  apsp_ram #(.WIDTH($bits(dist_row_t))) u_dist_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (dist_ctl),
    .wdata_i (dist_wdata),
    .rdata_o (dist_rdata)
  );

  // Active node count, clamped to 1..MAX_NODES
  always_comb begin
    if (cfg.node_count == '0) begin
      n_act = CFG_W'(1);
    end else if (cfg.node_count > CFG_W'(MAX_NODES)) begin
      n_act = CFG_W'(MAX_NODES);
    end else begin
      n_act = cfg.node_count;
    end
  end
  assign n_last = NODE_W'(n_act - CFG_W'(1));

  // Columns in use
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      col_mask[j] = CFG_W'(j) < n_act;
    end
  end

  // Handshake and execute-stage decode
  assign fwd_hit  = fwd_vld_q && (fwd_row_q == b_src_q);
  assign adj_cur  = fwd_hit ? fwd_adj_q : adj_rdata;
  assign dist_cur = fwd_hit ? fwd_dist_q : dist_rdata;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign b_run    = b_vld_q && (b_func_q == FUNC_RUN);
  assign b_go     = (state_q == ST_PIPE) && b_vld_q && !b_run && out_free;
  assign in_ready = (state_q == ST_PIPE) && (!b_vld_q || b_go);
  assign in_acc   = req_i.valid && in_ready;
  assign edge_ok  = (CFG_W'(b_src_q) < n_act) && (CFG_W'(b_dst_q) < n_act);
  assign add_wr   = b_go && (b_func_q == FUNC_ADD) && edge_ok;
  assign new_pair = dist_cur.levels[b_dst_q] == '0;

  // Pairs newly reached in the row being written back
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      new_bits[j] = acc_q[j] && (NODE_W'(j) != row_q) && (dist_rdata.levels[j] == '0);
    end
  end

  assign pair_sum = pair_q + round_add_q;
  assign stop     = (pair_sum >= full_q) || (level_q >= cfg.diameter_limit) ||
                    (round_add_q == '0) || (level_q >= LEVEL_CAP);

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    b_vld_d     = b_vld_q;
    b_func_d    = b_func_q;
    b_src_d     = b_src_q;
    b_dst_d     = b_dst_q;
    fwd_vld_d   = fwd_vld_q;
    fwd_row_d   = fwd_row_q;
    fwd_adj_d   = fwd_adj_q;
    fwd_dist_d  = fwd_dist_q;
    out_vld_d   = out_vld_q;
    o_dist_d    = o_dist_q;
    o_pairs_d   = o_pairs_q;
    o_level_d   = o_level_q;
    pair_d      = pair_q;
    full_d      = full_q;
    round_add_d = round_add_q;
    level_d     = level_q;
    final_d     = final_q;
    row_d       = row_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    new_d       = new_q;

    adj_ctl     = '0;
    dist_ctl    = '0;
    adj_wdata   = adj_cur | (row_t'(1) << b_dst_q);
    dist_wdata  = dist_cur;
    dist_wdata.levels[b_dst_q] = DIST_W'(1);

    if (out_vld_q && rsp_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_PIPE: begin
        // Finish the request in the execute stage
        if (b_go) begin
          adj_ctl.we     = add_wr;
          adj_ctl.waddr  = b_src_q;
          dist_ctl.we    = add_wr;
          dist_ctl.waddr = b_src_q;
          if (add_wr && new_pair) begin
            pair_d = pair_q + PAIR_W'(1);
          end
          out_vld_d = 1'b1;
          o_dist_d  = (b_func_q == FUNC_READ) ? dist_cur.levels[b_dst_q] : '0;
          o_pairs_d = pair_d;
          o_level_d = final_q;
          b_vld_d   = 1'b0;
        end
        // Take a new request and start its row reads
        if (in_acc) begin
          adj_ctl.re     = 1'b1;
          adj_ctl.raddr  = req_i.src;
          dist_ctl.re    = 1'b1;
          dist_ctl.raddr = req_i.src;
          b_vld_d        = 1'b1;
          b_func_d       = req_i.func;
          b_src_d        = req_i.src;
          b_dst_d        = req_i.dst;
          fwd_vld_d      = add_wr;
          fwd_row_d      = b_src_q;
          fwd_adj_d      = adj_wdata;
          fwd_dist_d     = dist_wdata;
        end
        // Run request: start copying adjacency into reach
        if (b_run) begin
          b_vld_d = 1'b0;
          row_d   = '0;
          full_d  = PAIR_W'(n_act) * PAIR_W'(n_act - CFG_W'(1));
          state_d = ST_CP_RD;
        end
      end

      ST_CP_RD: begin
        adj_ctl.re     = 1'b1;
        adj_ctl.raddr  = row_q;
        dist_ctl.re    = 1'b1;
        dist_ctl.raddr = row_q;
        state_d        = ST_CP_WR;
      end

      ST_CP_WR: begin
        dist_ctl.we       = 1'b1;
        dist_ctl.waddr    = row_q;
        dist_wdata.reach  = adj_rdata & col_mask;
        dist_wdata.levels = dist_rdata.levels;
        if (row_q == n_last) begin
          row_d       = '0;
          level_d     = DIST_W'(2);
          round_add_d = '0;
          state_d     = ST_ROW_RD;
        end else begin
          row_d   = row_q + NODE_W'(1);
          state_d = ST_CP_RD;
        end
      end

      ST_ROW_RD: begin
        dist_ctl.re    = 1'b1;
        dist_ctl.raddr = row_q;
        adj_ctl.re     = 1'b1;
        adj_ctl.raddr  = '0;
        cnt_d          = '0;
        acc_d          = '0;
        state_d        = ST_ACC;
      end

      // OR in adjacency row a wherever reach bit a is set
      ST_ACC: begin
        if (dist_rdata.reach[cnt_q]) begin
          acc_d = acc_q | (adj_rdata & col_mask);
        end
        if (cnt_q == n_last) begin
          state_d = ST_WB;
        end else begin
          adj_ctl.re    = 1'b1;
          adj_ctl.raddr = cnt_q + NODE_W'(1);
          cnt_d         = cnt_q + NODE_W'(1);
        end
      end

      ST_WB: begin
        dist_ctl.we      = 1'b1;
        dist_ctl.waddr   = row_q;
        dist_wdata.reach = acc_q;
        for (int j = 0; j < MAX_NODES; j++) begin
          dist_wdata.levels[j] = new_bits[j] ? level_q : dist_rdata.levels[j];
        end
        new_d   = new_bits;
        state_d = ST_CNT;
      end

      ST_CNT: begin
        round_add_d = round_add_q + PAIR_W'(popcount(new_q));
        if (row_q == n_last) begin
          state_d = ST_RND;
        end else begin
          row_d   = row_q + NODE_W'(1);
          state_d = ST_ROW_RD;
        end
      end

      // End of round: update the count and test the stop conditions
      ST_RND: begin
        pair_d = pair_sum;
        if (stop) begin
          final_d = level_q;
          state_d = ST_DONE;
        end else begin
          level_d     = level_q + DIST_W'(1);
          row_d       = '0;
          round_add_d = '0;
          state_d     = ST_ROW_RD;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          o_dist_d  = '0;
          o_pairs_d = pair_q;
          o_level_d = final_q;
          state_d   = ST_PIPE;
        end
      end

      default: begin
        state_d = ST_PIPE;
      end
    endcase
  end

  // State, counters and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_PIPE;
      b_vld_q     <= 1'b0;
      b_func_q    <= '0;
      b_src_q     <= '0;
      b_dst_q     <= '0;
      fwd_vld_q   <= 1'b0;
      fwd_row_q   <= '0;
      out_vld_q   <= 1'b0;
      o_dist_q    <= '0;
      o_pairs_q   <= '0;
      o_level_q   <= '0;
      pair_q      <= '0;
      full_q      <= '0;
      round_add_q <= '0;
      level_q     <= '0;
      final_q     <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      b_vld_q     <= b_vld_d;
      b_func_q    <= b_func_d;
      b_src_q     <= b_src_d;
      b_dst_q     <= b_dst_d;
      fwd_vld_q   <= fwd_vld_d;
      fwd_row_q   <= fwd_row_d;
      out_vld_q   <= out_vld_d;
      o_dist_q    <= o_dist_d;
      o_pairs_q   <= o_pairs_d;
      o_level_q   <= o_level_d;
      pair_q      <= pair_d;
      full_q      <= full_d;
      round_add_q <= round_add_d;
      level_q     <= level_d;
      final_q     <= final_d;
      row_q       <= row_d;
      cnt_q       <= cnt_d;
    end
  end

  // Wide data registers
  always_ff @(posedge clk_i) begin
    fwd_adj_q  <= fwd_adj_d;
    fwd_dist_q <= fwd_dist_d;
    acc_q      <= acc_d;
    new_q      <= new_d;
  end

  assign req_i.ready       = in_ready;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.distance    = o_dist_q;
  assign rsp_o.pairs_found = o_pairs_q;
  assign rsp_o.last_level  = o_level_q;

  // A taken request always lands in the execute stage
  a_acc_to_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> b_vld_q)
    else $error("accepted request missing from execute stage");

  // The pair count never goes down
  a_pairs_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (pair_q >= $past(pair_q)))
    else $error("pair count decreased");

  // No request is held in the execute stage while a run owns the memories
  a_run_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_PIPE) |-> !b_vld_q)
    else $error("request pending during run");

  // Rounds always start at level two or higher
  a_round_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_RD) |-> (level_q >= DIST_W'(2)))
    else $error("round started below level two");

  // A stalled request keeps its row in the execute stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIPE && b_vld_q && !b_run && !out_free) |=>
    (b_vld_q && $stable(b_src_q)))
    else $error("stalled request lost");

endmodule
